>>> rtl/nldc_pkg.sv
// Shared types and constants for the note LED depth coalescer.
`timescale 1ns / 1ps
`default_nettype none

package nldc_pkg;

  // Opcodes carried on the request channel
  localparam logic [2:0] OP_NOTE_ON  = 3'd0;
  localparam logic [2:0] OP_NOTE_OFF = 3'd1;
  localparam logic [2:0] OP_REFRESH  = 3'd2;
  localparam logic [2:0] OP_MAP_WR   = 3'd3;
  localparam logic [2:0] OP_DEPTH_RD = 3'd4;

  // Classified work kinds handed from front to back
  localparam logic [2:0] KIND_NOP      = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd2;
  localparam logic [2:0] KIND_REFRESH  = 3'd3;
  localparam logic [2:0] KIND_MAP_WR   = 3'd4;
  localparam logic [2:0] KIND_DEPTH_RD = 3'd5;

  // Configuration register indexes (byte address 4 * index)
  localparam int         PADDR_W       = 4;
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_MAX_DEFER = 2'd2;

  localparam logic [15:0] WINDOW_RESET    = 16'd1000;
  localparam logic [15:0] MAX_DEFER_RESET = 16'd8000;
  localparam logic [7:0]  DEPTH_MAX       = 8'd255;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  note;
    logic [31:0] time_us;
    logic [1:0]  word_sel;
    logic [63:0] word;
    logic [7:0]  led;
  } cmd_t;

  typedef struct packed {
    logic        defer;
    logic        changed;
    logic [7:0]  depth;
  } res_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] window;
    logic [15:0] max_defer;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/nldc_ifs.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

interface nldc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [6:0]  note;
  logic [31:0] time_us;
  logic [1:0]  map_word_select;
  logic [63:0] map_word;
  logic [7:0]  led_index;

  modport source (
    output valid, opcode, note, time_us, map_word_select, map_word, led_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, note, time_us, map_word_select, map_word, led_index,
    output ready
  );
endinterface

interface nldc_rsp_if;
  logic       valid;
  logic       ready;
  logic       defer_refresh;
  logic       depth_changed;
  logic [7:0] depth;

  modport source (
    output valid, defer_refresh, depth_changed, depth,
    input  ready
  );
  modport sink (
    input  valid, defer_refresh, depth_changed, depth,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/note_led_depth_coalescer.sv
// Top level: configuration registers, front end, command queue and back end.
//
//  channel  dir  handshake               payload
//  req      in   valid/ready             opcode, note, time_us, map_word_select,
//                                        map_word, led_index
//  rsp      out  valid/ready             defer_refresh, depth_changed, depth
//  apb      in   psel/penable, pready=1  paddr, pwdata, prdata
//
//  A note on/off spends most of its time in the LED walk: one depth counter is
//  read per cycle and written back when its mask bit is set and it does not saturate.
//  After reset a clearing pass zeroes both memories; req.ready stays low during
//  it. The queue holds two transactions, so the front keeps accepting while the
//  back works or a result waits on rsp.
`timescale 1ns / 1ps
`default_nettype none

module note_led_depth_coalescer #(
  parameter int LED_TOTAL  = 140,
  parameter int NOTE_TOTAL = 128,
  parameter int MASK_WORDS = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  nldc_req_if.sink                     req,
  nldc_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nldc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  nldc_pkg::cfg_t cfg;
  logic           cfg_wr;
  logic [1:0]     reg_idx;

  logic           clearing;
  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  nldc_pkg::cmd_t push_cmd;
  nldc_pkg::cmd_t q_head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= 1'b0;
      cfg.window    <= nldc_pkg::WINDOW_RESET;
      cfg.max_defer <= nldc_pkg::MAX_DEFER_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        nldc_pkg::REG_MODE:      cfg.mode      <= pwdata[0];
        nldc_pkg::REG_WINDOW:    cfg.window    <= pwdata[15:0];
        nldc_pkg::REG_MAX_DEFER: cfg.max_defer <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      nldc_pkg::REG_MODE:      prdata = {31'd0, cfg.mode};
      nldc_pkg::REG_WINDOW:    prdata = {16'd0, cfg.window};
      nldc_pkg::REG_MAX_DEFER: prdata = {16'd0, cfg.max_defer};
      default:                 prdata = 32'd0;
    endcase
  end

  nldc_front #(
    .LED_TOTAL  (LED_TOTAL),
    .NOTE_TOTAL (NOTE_TOTAL),
    .MASK_WORDS (MASK_WORDS)
  ) u_front (
    .req      (req),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  nldc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  nldc_back #(
    .LED_TOTAL  (LED_TOTAL),
    .NOTE_TOTAL (NOTE_TOTAL),
    .MASK_WORDS (MASK_WORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

>>> rtl/nldc_front.sv
// Front end: accepts request transactions and classifies them into work kinds.
`timescale 1ns / 1ps
`default_nettype none

module nldc_front #(
  parameter int LED_TOTAL  = 140,
  parameter int NOTE_TOTAL = 128,
  parameter int MASK_WORDS = 3
) (
  nldc_req_if.sink         req,
  input  logic             clearing,
  input  logic             q_full,
  output logic             push,
  output nldc_pkg::cmd_t   push_cmd
);

  logic note_ok;
  logic sel_ok;
  logic led_ok;

  assign note_ok = 32'(req.note) < 32'(NOTE_TOTAL);
  assign sel_ok  = 32'(req.map_word_select) < 32'(MASK_WORDS);
  assign led_ok  = 32'(req.led_index) < 32'(LED_TOTAL);

  assign req.ready = !q_full && !clearing;
  assign push      = req.valid && req.ready;

  always_comb begin
    push_cmd.note     = req.note;
    push_cmd.time_us  = req.time_us;
    push_cmd.word_sel = req.map_word_select;
    push_cmd.word     = req.map_word;
    push_cmd.led      = req.led_index;
    unique case (req.opcode)
      nldc_pkg::OP_NOTE_ON: begin
        push_cmd.kind = note_ok ? nldc_pkg::KIND_NOTE_ON : nldc_pkg::KIND_NOP;
      end
      nldc_pkg::OP_NOTE_OFF: begin
        push_cmd.kind = note_ok ? nldc_pkg::KIND_NOTE_OFF : nldc_pkg::KIND_NOP;
      end
      nldc_pkg::OP_REFRESH: begin
        push_cmd.kind = nldc_pkg::KIND_REFRESH;
      end
      nldc_pkg::OP_MAP_WR: begin
        push_cmd.kind = (note_ok && sel_ok) ? nldc_pkg::KIND_MAP_WR : nldc_pkg::KIND_NOP;
      end
      nldc_pkg::OP_DEPTH_RD: begin
        push_cmd.kind = led_ok ? nldc_pkg::KIND_DEPTH_RD : nldc_pkg::KIND_NOP;
      end
      default: begin
        push_cmd.kind = nldc_pkg::KIND_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/nldc_queue.sv
// Short command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module nldc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  nldc_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output nldc_pkg::cmd_t   head
);

  localparam int QP_W = (nldc_pkg::QUEUE_DEPTH > 1) ? $clog2(nldc_pkg::QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(nldc_pkg::QUEUE_DEPTH + 1);

  nldc_pkg::cmd_t    entries [nldc_pkg::QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr;
  logic [QP_W-1:0]   rd_ptr;
  logic [QC_W-1:0]   count;

  assign full  = count == QC_W'(nldc_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(nldc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP_W'(nldc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nldc_back.sv
// Back end: map and depth memories, LED walk, refresh tracking and result register.
`timescale 1ns / 1ps
`default_nettype none

module nldc_back #(
  parameter int LED_TOTAL  = 140,
  parameter int NOTE_TOTAL = 128,
  parameter int MASK_WORDS = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  nldc_pkg::cfg_t   cfg,
  input  logic             q_empty,
  input  nldc_pkg::cmd_t   q_head,
  output logic             q_pop,
  output logic             clearing,
  nldc_rsp_if.source       rsp
);

  localparam int MAP_DEPTH = NOTE_TOTAL * MASK_WORDS;
  localparam int CLR_COUNT = (MAP_DEPTH > LED_TOTAL) ? MAP_DEPTH : LED_TOTAL;
  localparam int MA_W      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int LED_W     = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
  localparam int CLR_W     = (CLR_COUNT > 1) ? $clog2(CLR_COUNT) : 1;
  localparam int WS_W      = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
  localparam int MASK_BITS = MASK_WORDS * 64;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_MRD    = 4'd2;
  localparam logic [3:0] ST_MFILL  = 4'd3;
  localparam logic [3:0] ST_WALK   = 4'd4;
  localparam logic [3:0] ST_WDRAIN = 4'd5;
  localparam logic [3:0] ST_MWR    = 4'd6;
  localparam logic [3:0] ST_DRD    = 4'd7;
  localparam logic [3:0] ST_DWAIT  = 4'd8;
  localparam logic [3:0] ST_RCHK   = 4'd9;
  localparam logic [3:0] ST_FIN    = 4'd10;

  logic [63:0]          map_mem [MAP_DEPTH];
  logic [7:0]           depth_mem [LED_TOTAL];

  logic [3:0]           state;
  logic [CLR_W-1:0]     clr_cnt;
  logic [WS_W-1:0]      rd_cnt;
  logic [LED_W-1:0]     led_cnt;
  nldc_pkg::cmd_t       cur;
  logic [MASK_BITS-1:0] mask;
  logic                 map_rd_v;
  logic                 p_v;
  logic [LED_W-1:0]     p_led;
  logic                 p_hit;
  logic                 chg;
  nldc_pkg::res_t       res;
  logic                 dirty;
  logic [31:0]          first_t;
  logic [31:0]          last_t;
  logic                 out_v;
  nldc_pkg::res_t       out_r;

  logic [63:0]          map_q;
  logic [7:0]           dep_q;
  logic                 map_we;
  logic [MA_W-1:0]      map_wa;
  logic [63:0]          map_wd;
  logic [MA_W-1:0]      map_ra;
  logic                 dep_we;
  logic [LED_W-1:0]     dep_wa;
  logic [7:0]           dep_wd;
  logic [LED_W-1:0]     dep_ra;

  logic [31:0]          note_base;
  logic                 clr_in_map;
  logic                 clr_in_led;
  logic                 up;
  logic                 note_evt;
  logic                 step_ok;
  logic                 walk_we;
  logic [31:0]          since_last;
  logic [31:0]          since_first;
  logic                 quiet;
  logic                 too_long;
  logic                 hold_off;
  logic                 fin_go;

  assign note_base  = 32'(cur.note) * 32'(MASK_WORDS);
  assign clr_in_map = 32'(clr_cnt) < 32'(MAP_DEPTH);
  assign clr_in_led = 32'(clr_cnt) < 32'(LED_TOTAL);
  assign up         = cur.kind == nldc_pkg::KIND_NOTE_ON;
  assign note_evt   = (cur.kind == nldc_pkg::KIND_NOTE_ON) ||
                      (cur.kind == nldc_pkg::KIND_NOTE_OFF);

  // saturating step on the counter read back in the previous cycle
  assign step_ok = up ? (dep_q != nldc_pkg::DEPTH_MAX) : (dep_q != 8'd0);
  assign walk_we = p_v && p_hit && step_ok;

  assign since_last  = cur.time_us - last_t;
  assign since_first = cur.time_us - first_t;
  assign quiet       = since_last < 32'(cfg.window);
  assign too_long    = since_first >= 32'(cfg.max_defer);
  assign hold_off    = dirty && cfg.mode && quiet && !too_long;

  assign clearing = state == ST_CLEAR;
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign fin_go   = (state == ST_FIN) && (!out_v || rsp.ready);

  assign map_we = (clearing && clr_in_map) || (state == ST_MWR);
  assign map_wa = clearing ? clr_cnt[MA_W-1:0] : MA_W'(note_base + 32'(cur.word_sel));
  assign map_wd = clearing ? 64'd0 : cur.word;
  assign map_ra = MA_W'(note_base + 32'(rd_cnt));

  assign dep_we = (clearing && clr_in_led) || walk_we;
  assign dep_wa = clearing ? clr_cnt[LED_W-1:0] : p_led;
  assign dep_wd = clearing ? 8'd0 : (up ? dep_q + 8'd1 : dep_q - 8'd1);
  assign dep_ra = (state == ST_WALK) ? led_cnt : cur.led[LED_W-1:0];

  assign rsp.valid         = out_v;
  assign rsp.defer_refresh = out_r.defer;
  assign rsp.depth_changed = out_r.changed;
  assign rsp.depth         = out_r.depth;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      depth_mem[dep_wa] <= dep_wd;
    end
    dep_q <= depth_mem[dep_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      rd_cnt   <= '0;
      led_cnt  <= '0;
      map_rd_v <= 1'b0;
      p_v      <= 1'b0;
      chg      <= 1'b0;
      dirty    <= 1'b0;
      first_t  <= '0;
      last_t   <= '0;
      out_v    <= 1'b0;
    end else begin
      map_rd_v <= state == ST_MRD;
      p_v      <= state == ST_WALK;
      if (walk_we) begin
        chg <= 1'b1;
      end
      if (fin_go) begin
        out_v <= 1'b1;
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_W'(CLR_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            chg     <= 1'b0;
            rd_cnt  <= '0;
            led_cnt <= '0;
            unique case (q_head.kind)
              nldc_pkg::KIND_NOTE_ON:  state <= ST_MRD;
              nldc_pkg::KIND_NOTE_OFF: state <= ST_MRD;
              nldc_pkg::KIND_REFRESH:  state <= ST_RCHK;
              nldc_pkg::KIND_MAP_WR:   state <= ST_MWR;
              nldc_pkg::KIND_DEPTH_RD: state <= ST_DRD;
              default:                 state <= ST_FIN;
            endcase
          end
        end
        ST_MRD: begin
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt == WS_W'(MASK_WORDS - 1)) begin
            state <= ST_MFILL;
          end
        end
        ST_MFILL: begin
          state <= ST_WALK;
        end
        ST_WALK: begin
          led_cnt <= led_cnt + 1'b1;
          if (led_cnt == LED_W'(LED_TOTAL - 1)) begin
            state <= ST_WDRAIN;
          end
        end
        ST_WDRAIN: begin
          state <= ST_FIN;
        end
        ST_MWR: begin
          state <= ST_FIN;
        end
        ST_DRD: begin
          state <= ST_DWAIT;
        end
        ST_DWAIT: begin
          state <= ST_FIN;
        end
        ST_RCHK: begin
          if (dirty && cfg.mode && !hold_off) begin
            dirty <= 1'b0;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            state <= ST_IDLE;
            if (note_evt && chg && cfg.mode) begin
              if (!dirty) begin
                dirty   <= 1'b1;
                first_t <= cur.time_us;
              end
              last_t <= cur.time_us;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
      res <= '0;
    end
    if (map_rd_v) begin
      mask <= (mask >> 64) | (MASK_BITS'(map_q) << (MASK_BITS - 64));
    end else if (state == ST_WALK) begin
      mask <= mask >> 1;
    end
    p_led <= led_cnt;
    p_hit <= mask[0];
    if (state == ST_DWAIT) begin
      res.depth <= dep_q;
    end
    if (state == ST_RCHK) begin
      res.defer <= hold_off;
    end
    if (fin_go) begin
      out_r <= '{defer: res.defer, changed: note_evt && chg, depth: res.depth};
    end
  end

endmodule

`default_nettype wire

>>> rtl/nldc_checker.sv
// Port-level assertions for the coalescer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nldc_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       defer_refresh,
  input logic       depth_changed,
  input logic [7:0] depth
);

  // transactions accepted on req but not yet delivered on rsp
  logic [2:0] pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
      pend <= pend + 1'b1;
    end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
      pend <= pend - 1'b1;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request accepted during clearing pass");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({defer_refresh, depth_changed, depth}))
    else $error("stalled response changed");

  a_one_field: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot0({defer_refresh, depth_changed, depth != 8'd0}))
    else $error("more than one result field set");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pend != 3'd0)
    else $error("response without an outstanding request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pend <= 3'd4)
    else $error("more transactions in flight than storage allows");

endmodule

bind note_led_depth_coalescer nldc_checker u_nldc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .defer_refresh (rsp.defer_refresh),
  .depth_changed (rsp.depth_changed),
  .depth         (rsp.depth)
);

`default_nettype wire

>>> sim/nldc_checker.sv
// Checker for the note LED depth coalescer: predicts each response and compares it.
`timescale 1ns / 1ps

module nldc_scoreboard #(
  parameter int LED_TOTAL  = 140,
  parameter int NOTE_TOTAL = 128,
  parameter int MASK_WORDS = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  nldc_req_if                          req,
  nldc_rsp_if                          rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [nldc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output int                           fails,
  output int                           outstanding
);

  logic [63:0]    led_mask  [NOTE_TOTAL*MASK_WORDS];
  logic [7:0]     led_level [LED_TOTAL];
  logic           dirty;
  logic [31:0]    first_change;
  logic [31:0]    last_change;
  nldc_pkg::cfg_t cfg;
  nldc_pkg::res_t pending_rsp[$];
  int             reported;

  function automatic nldc_pkg::res_t apply_command(
    input logic [2:0] op, input logic [6:0] nt,
    input logic [31:0] now, input logic [1:0] sel,
    input logic [63:0] word, input logic [7:0] led);
    nldc_pkg::res_t r;
    logic           hit;
    logic           quiet;
    logic           overdue;
    logic [31:0]    since_last;
    logic [31:0]    since_first;
    int             w;
    int             b;
    int             led_no;
    r   = '0;
    hit = 1'b0;
    case (op)
      nldc_pkg::OP_NOTE_ON, nldc_pkg::OP_NOTE_OFF: begin
        if (int'(nt) < NOTE_TOTAL) begin
          for (w = 0; w < MASK_WORDS; w++) begin
            for (b = 0; b < 64; b++) begin
              led_no = w * 64 + b;
              if (led_mask[int'(nt) * MASK_WORDS + w][b] && led_no < LED_TOTAL) begin
                if (op == nldc_pkg::OP_NOTE_ON) begin
                  if (led_level[led_no] < nldc_pkg::DEPTH_MAX) begin
                    led_level[led_no]++;
                    hit = 1'b1;
                  end
                end else if (led_level[led_no] > 8'd0) begin
                  led_level[led_no]--;
                  hit = 1'b1;
                end
              end
            end
          end
        end
        if (hit) begin
          r.changed = 1'b1;
          if (cfg.mode) begin
            if (!dirty) begin
              dirty        = 1'b1;
              first_change = now;
            end
            last_change = now;
          end
        end
      end
      nldc_pkg::OP_REFRESH: begin
        if (dirty && cfg.mode) begin
          since_last  = now - last_change;
          since_first = now - first_change;
          quiet       = since_last < {16'd0, cfg.window};
          overdue     = since_first >= {16'd0, cfg.max_defer};
          if (quiet && !overdue) r.defer = 1'b1;
          else dirty = 1'b0;
        end
      end
      nldc_pkg::OP_MAP_WR: begin
        if (int'(nt) < NOTE_TOTAL && int'(sel) < MASK_WORDS)
          led_mask[int'(nt) * MASK_WORDS + int'(sel)] = word;
      end
      nldc_pkg::OP_DEPTH_RD: begin
        if (int'(led) < LED_TOTAL) r.depth = led_level[led];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    nldc_pkg::res_t want;
    nldc_pkg::res_t got;
    if (rst) begin
      foreach (led_mask[i]) led_mask[i] = '0;
      foreach (led_level[i]) led_level[i] = '0;
      dirty         = 1'b0;
      first_change  = '0;
      last_change   = '0;
      cfg.mode      = 1'b0;
      cfg.window    = nldc_pkg::WINDOW_RESET;
      cfg.max_defer = nldc_pkg::MAX_DEFER_RESET;
      pending_rsp.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[nldc_pkg::PADDR_W-1:2])
          nldc_pkg::REG_MODE:      cfg.mode      = pwdata[0];
          nldc_pkg::REG_WINDOW:    cfg.window    = pwdata[15:0];
          nldc_pkg::REG_MAX_DEFER: cfg.max_defer = pwdata[15:0];
          default: ;
        endcase
      end
      // responses first: nothing accepted this edge can already be answered
      if (rsp.valid && rsp.ready) begin
        got.defer   = rsp.defer_refresh;
        got.changed = rsp.depth_changed;
        got.depth   = rsp.depth;
        if (pending_rsp.size() == 0) begin
          fails++;
          if (reported < 10)
            $display("%0t: unexpected response defer=%0b changed=%0b depth=%0d",
                     $realtime, got.defer, got.changed, got.depth);
          reported++;
        end else begin
          want = pending_rsp.pop_front();
          if (got.defer !== want.defer || got.changed !== want.changed ||
              got.depth !== want.depth) begin
            fails++;
            if (reported < 10)
              $display("%0t: mismatch exp defer=%0b changed=%0b depth=%0d",
                       $realtime, want.defer, want.changed, want.depth,
                       ", got defer=%0b changed=%0b depth=%0d",
                       got.defer, got.changed, got.depth);
            reported++;
          end
        end
      end
      if (req.valid && req.ready)
        pending_rsp.push_back(apply_command(req.opcode, req.note, req.time_us,
                                            req.map_word_select, req.map_word,
                                            req.led_index));
    end
    outstanding = pending_rsp.size();
  end

endmodule

>>> sim/tb_note_led_depth_coalescer.sv
// Testbench top for the note LED depth coalescer: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb_note_led_depth_coalescer;

  localparam int LEDS        = 140;
  localparam int NOTES       = 128;
  localparam int WORDS       = 3;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_LEN    = 400;
  localparam int NO_HOLD     = -1;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [nldc_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;
  int                           fails;
  int                           outstanding;
  int                           idle_cycles;
  logic                         req_gaps;
  logic                         rsp_gaps;
  logic                         hold_req;
  logic [31:0]                  now_us;

  nldc_req_if req_ch ();
  nldc_rsp_if rsp_ch ();

  note_led_depth_coalescer #(
    .LED_TOTAL  (LEDS),
    .NOTE_TOTAL (NOTES),
    .MASK_WORDS (WORDS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  nldc_scoreboard #(
    .LED_TOTAL  (LEDS),
    .NOTE_TOTAL (NOTES),
    .MASK_WORDS (WORDS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fails       (fails),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // response side: random back-pressure, plus one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        rsp_ch.ready <= !rsp_gaps || ($urandom_range(99) >= 9);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_note_led_depth_coalescer: FAIL");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [2:0] op, input logic [6:0] nt,
                           input logic [31:0] t, input logic [1:0] sel,
                           input logic [63:0] word, input logic [7:0] led);
    while (req_gaps && $urandom_range(99) < 9) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.opcode          <= op;
    req_ch.note            <= nt;
    req_ch.time_us         <= t;
    req_ch.map_word_select <= sel;
    req_ch.map_word        <= word;
    req_ch.led_index       <= led;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // drain, then set the registers while the block is idle
  task automatic configure(input logic mode, input logic [15:0] window,
                           input logic [15:0] max_defer, input logic gaps);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
    reg_write(nldc_pkg::REG_MODE, {31'd0, mode});
    reg_write(nldc_pkg::REG_WINDOW, {16'd0, window});
    reg_write(nldc_pkg::REG_MAX_DEFER, {16'd0, max_defer});
    req_gaps = gaps;
    rsp_gaps = gaps;
  endtask

  task automatic send_random(input int note_pct, input int up_pct, input int hot_count);
    logic [2:0]  op;
    logic [6:0]  nt;
    logic [1:0]  sel;
    logic [63:0] word;
    logic [7:0]  led;
    int          k;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: now_us += $urandom_range(300);
      5, 6, 7:       now_us += $urandom_range(5000);
      8:             now_us += $urandom_range(70000);
      default: begin
        if ($urandom_range(3) == 0) now_us = $urandom;
        else now_us += $urandom_range(20000);
      end
    endcase
    if ($urandom_range(99) < note_pct) begin
      op = ($urandom_range(99) < up_pct) ? nldc_pkg::OP_NOTE_ON : nldc_pkg::OP_NOTE_OFF;
    end else begin
      k = $urandom_range(19);
      if (k < 7)       op = nldc_pkg::OP_REFRESH;
      else if (k < 12) op = nldc_pkg::OP_MAP_WR;
      else if (k < 18) op = nldc_pkg::OP_DEPTH_RD;
      else             op = 3'(nldc_pkg::OP_DEPTH_RD + $urandom_range(1, 3));
    end
    nt  = ($urandom_range(99) < 80) ? 7'($urandom_range(hot_count - 1))
                                    : 7'($urandom_range(127));
    sel = ($urandom_range(9) == 0) ? 2'(WORDS) : 2'($urandom_range(WORDS - 1));
    case ($urandom_range(5))
      0: word = '1;
      1: word = '0;
      2: word = {$urandom, $urandom};
      default: begin
        word = '0;
        repeat ($urandom_range(1, 6)) word[$urandom_range(63)] = 1'b1;
      end
    endcase
    led = ($urandom_range(9) == 0) ? 8'($urandom_range(LEDS, 255))
                                   : 8'($urandom_range(LEDS - 1));
    send_item(op, nt, now_us, sel, word, led);
  endtask

  task automatic run_phase(input logic mode, input logic [15:0] window,
                           input logic [15:0] max_defer, input int count,
                           input int note_pct, input int up_pct, input int hot_count,
                           input logic gaps, input int hold_at);
    int i;
    configure(mode, window, max_defer, gaps);
    for (i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      send_random(note_pct, up_pct, hot_count);
    end
  endtask

  initial begin
    int k;
    rst                    <= 1'b1;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    req_ch.valid           <= 1'b0;
    req_ch.opcode          <= nldc_pkg::OP_NOTE_ON;
    req_ch.note            <= '0;
    req_ch.time_us         <= '0;
    req_ch.map_word_select <= '0;
    req_ch.map_word        <= '0;
    req_ch.led_index       <= '0;
    req_gaps    = 1'b0;
    rsp_gaps    = 1'b0;
    hold_req    = 1'b0;
    now_us      = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: full and partial masks, edges of the LED range, deferral and wrap
    configure(1'b1, 16'd1000, 16'd8000, 1'b1);
    send_item(nldc_pkg::OP_MAP_WR, 7'd0, 32'd0, 2'd0, '1, '0);
    send_item(nldc_pkg::OP_MAP_WR, 7'd0, 32'd0, 2'd1, '1, '0);
    send_item(nldc_pkg::OP_MAP_WR, 7'd0, 32'd0, 2'd2, '1, '0);
    send_item(nldc_pkg::OP_MAP_WR, 7'd127, 32'd0, 2'd3, '1, '0);
    send_item(nldc_pkg::OP_MAP_WR, 7'd127, 32'd0, 2'd2, 64'h8000_0000_0000_0801, '0);
    send_item(nldc_pkg::OP_NOTE_OFF, 7'd0, 32'd100, '0, '0, '0);
    send_item(nldc_pkg::OP_REFRESH, '0, 32'd100, '0, '0, '0);
    send_item(nldc_pkg::OP_NOTE_ON, 7'd0, 32'd200, '0, '0, '0);
    send_item(nldc_pkg::OP_NOTE_ON, 7'd127, 32'd500, '0, '0, '0);
    send_item(nldc_pkg::OP_REFRESH, '0, 32'd900, '0, '0, '0);
    send_item(nldc_pkg::OP_DEPTH_RD, '0, 32'd900, '0, '0, 8'd0);
    send_item(nldc_pkg::OP_DEPTH_RD, '0, 32'd900, '0, '0, 8'd139);
    send_item(nldc_pkg::OP_DEPTH_RD, '0, 32'd900, '0, '0, 8'd140);
    send_item(nldc_pkg::OP_DEPTH_RD, '0, 32'd900, '0, '0, 8'd255);
    send_item(nldc_pkg::OP_REFRESH, '0, 32'd1600, '0, '0, '0);
    send_item(nldc_pkg::OP_NOTE_ON, 7'd5, 32'd1700, '0, '0, '0);
    for (k = 1; k <= 3; k++) send_item(3'(nldc_pkg::OP_DEPTH_RD + k), '1, '1, '1, '1, '1);
    send_item(nldc_pkg::OP_NOTE_OFF, 7'd127, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(nldc_pkg::OP_REFRESH, '0, 32'h0000_0010, '0, '0, '0);
    send_item(nldc_pkg::OP_NOTE_OFF, 7'd0, 32'd0, '0, '0, '0);
    send_item(nldc_pkg::OP_DEPTH_RD, '0, 32'd0, '0, '0, 8'd128);

    now_us = 32'd5000;
    run_phase(1'b1, 16'd3000, 16'd20000, 300, 50, 60, 8, 1'b1, NO_HOLD);

    // two hot notes driven hard upwards to reach saturation; long sink hold-off
    configure(1'b1, 16'd0, 16'hFFFF, 1'b1);
    for (k = 0; k < 2 * WORDS; k++) begin
      send_item(nldc_pkg::OP_MAP_WR, 7'(k / WORDS), now_us, 2'(k % WORDS), '1, '0);
    end
    run_phase(1'b1, 16'd0, 16'hFFFF, 450, 80, 95, 2, 1'b1, 100);

    run_phase(1'b1, 16'hFFFF, 16'd0, 200, 50, 50, 8, 1'b0, NO_HOLD);
    now_us = 32'hFFFF_8000;
    run_phase(1'b1, 16'hFFFF, 16'hFFFF, 250, 50, 40, 8, 1'b1, NO_HOLD);
    run_phase(1'b0, 16'($urandom), 16'($urandom), 200, 50, 50, 8, 1'b1, NO_HOLD);
    run_phase(1'b1, 16'($urandom_range(200, 6000)), 16'($urandom_range(1000, 30000)),
              300, 60, 10, 4, 1'b1, NO_HOLD);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (200) @(posedge clk);
    if (fails == 0)
      $display("tb_note_led_depth_coalescer: PASS");
    else
      $display("tb_note_led_depth_coalescer: FAIL");
    $finish;
  end

endmodule
